FILE: rtl/fifo_queue_with_cancel_by_id_core_assert.svh
// Assertion macros for the cancel-by-id queue core.
// Each macro places one labeled concurrent assertion clocked on clk,
// disabled while rst_n is low.
`ifndef FIFO_QUEUE_WITH_CANCEL_BY_ID_CORE_ASSERT_SVH
`define FIFO_QUEUE_WITH_CANCEL_BY_ID_CORE_ASSERT_SVH

// Same-cycle implication.
`define FQC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FQC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqc_pkg
// Shared types, codes and defaults for the cancel-by-id queue.
// ----------------------------------------------------------------------------
package fqc_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 16;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ    = 2'd0,
    KIND_DEQ    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Contents of one queue slot.
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
  } slot_t;

  // Signals rippling from the front of the chain toward the back.
  typedef struct packed {
    logic hit;    // a matching entry sits at or in front of this point
    logic shift;  // this point and everything behind it moves forward
  } chain_t;

  // Per-transaction command broadcast to every cell.
  typedef struct packed {
    logic            en;      // transaction accepted this cycle
    logic            cancel;  // cancel request: remove first match
    logic [ID_W-1:0] key;
  } cell_cmd_t;

endpackage

FILE: rtl/fqc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqc_cell
// One queue slot: holds an entry, compares it with the key and takes its
// back neighbor's entry when the queue closes a gap.
// ----------------------------------------------------------------------------
module fqc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fqc_pkg::cell_cmd_t cmd,
  input  logic               load,
  input  fqc_pkg::slot_t     load_slot,
  input  fqc_pkg::slot_t     nbr_slot,
  input  fqc_pkg::chain_t    chain_in,
  output fqc_pkg::chain_t    chain_out,
  output logic               first_hit,
  output fqc_pkg::slot_t     slot_out
);
  import fqc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              match;
  logic              shift;

  assign match     = valid_r && (id_r == cmd.key);
  assign first_hit = match && !chain_in.hit;
  assign shift     = chain_in.shift || (cmd.cancel && first_hit);

  assign chain_out.hit   = chain_in.hit || match;
  assign chain_out.shift = shift;

  assign slot_out.valid = valid_r;
  assign slot_out.id    = id_r;
  assign slot_out.data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    data_nxt  = data_r;
    if (cmd.en) begin
      if (load) begin
        valid_nxt = 1'b1;
        id_nxt    = load_slot.id;
        data_nxt  = load_slot.data;
      end else if (shift) begin
        // advance the back neighbor into this slot
        valid_nxt = nbr_slot.valid;
        id_nxt    = nbr_slot.id;
        data_nxt  = nbr_slot.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/fifo_queue_with_cancel_by_id_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_cancel_by_id_core
// Ordered id/data queue built as a chain of slot cells, with enqueue,
// dequeue, cancel of the first matching id and lookup by id.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+---------------------------------------------------
//  in      | input     | in_valid, in_stall, in_kind, in_entry_id, in_entry_data
//  out     | output    | out_valid, out_stall, out_status, out_found_id,
//          |           | out_found_data, out_occupancy, out_is_empty
//
//  One transaction per cycle while no result is held by out_stall; each
//  result appears in the output register in the cycle after acceptance.
//  Compare, first-match ripple and neighbor shift all finish in the cycle of
//  acceptance inside the cell chain. Reset clears the slot valid bits and
//  the entry count. in_stall is high only while a result is held by out_stall.
// ----------------------------------------------------------------------------
module fifo_queue_with_cancel_by_id_core #(
  parameter int DEPTH = fqc_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fqc_pkg::KIND_W-1:0]  in_kind,
  input  logic [fqc_pkg::ID_W-1:0]    in_entry_id,
  input  logic [fqc_pkg::DATA_W-1:0]  in_entry_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fqc_pkg::STATUS_W-1:0] out_status,
  output logic [fqc_pkg::ID_W-1:0]    out_found_id,
  output logic [fqc_pkg::DATA_W-1:0]  out_found_data,
  output logic [fqc_pkg::OCC_W-1:0]   out_occupancy,
  output logic                        out_is_empty
);
  import fqc_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             accept;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full, empty;
  logic             is_enq, is_deq, is_cancel, is_lookup;
  logic             enq_go, deq_go;

  cell_cmd_t        cmd;
  slot_t            load_slot;
  slot_t            cell_slot [DEPTH];
  chain_t           chain [DEPTH+1];
  logic [DEPTH-1:0] first_hit;
  logic [DEPTH-1:0] valid_vec;
  logic             found;
  slot_t            hit_slot;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]     fid_r, fid_nxt;
  logic [DATA_W-1:0]   fdata_r, fdata_nxt;
  logic [CNT_W-1:0]    occ_r;
  logic                empty_flag_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  assign is_enq    = (in_kind == KIND_ENQ);
  assign is_deq    = (in_kind == KIND_DEQ);
  assign is_cancel = (in_kind == KIND_CANCEL);
  assign is_lookup = (in_kind == KIND_LOOKUP);

  assign enq_go = is_enq && !full;
  assign deq_go = is_deq && !empty;

  assign cmd.en     = accept;
  assign cmd.cancel = is_cancel;
  assign cmd.key    = in_entry_id;

  assign load_slot.valid = 1'b1;
  assign load_slot.id    = in_entry_id;
  assign load_slot.data  = in_entry_data;

  // dequeue starts the shift at the head cell
  assign chain[0].hit   = 1'b0;
  assign chain[0].shift = deq_go;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t nbr;
    if (i == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_slot[i+1];
    end

    fqc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .load      (enq_go && (cnt_r == CNT_W'(i))),
      .load_slot (load_slot),
      .nbr_slot  (nbr),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .first_hit (first_hit[i]),
      .slot_out  (cell_slot[i])
    );

    assign valid_vec[i] = cell_slot[i].valid;
  end

  assign found = chain[DEPTH].hit;

  // first_hit has at most one bit set, so an AND-OR select suffices
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_slot = hit_slot | (cell_slot[i] & {$bits(slot_t){first_hit[i]}});
    end
  end

  always_comb begin
    status_nxt = ST_DONE;
    fid_nxt    = '0;
    fdata_nxt  = '0;
    cnt_nxt    = cnt_r;
    if (is_enq) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else if (is_deq) begin
      if (empty) begin
        status_nxt = ST_MISS;
      end else begin
        fid_nxt   = cell_slot[0].id;
        fdata_nxt = cell_slot[0].data;
        cnt_nxt   = cnt_r - CNT_W'(1);
      end
    end else if (is_cancel || is_lookup) begin
      if (!found) begin
        status_nxt = ST_MISS;
      end else begin
        fid_nxt   = hit_slot.id;
        fdata_nxt = hit_slot.data;
        if (is_cancel) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      fid_r        <= fid_nxt;
      fdata_r      <= fdata_nxt;
      occ_r        <= cnt_nxt;
      empty_flag_r <= (cnt_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_found_id   = fid_r;
  assign out_found_data = fdata_r;
  assign out_occupancy  = OCC_W'(occ_r);
  assign out_is_empty   = empty_flag_r;

`include "fifo_queue_with_cancel_by_id_core_assert.svh"

  `FQC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DEPTH), "entry count above depth")
  `FQC_ASSERT_IMP(a_valid_count, 1'b1, $countones(valid_vec) == int'(cnt_r), "valid bits disagree with count")
  `FQC_ASSERT_IMP(a_first_onehot, 1'b1, $onehot0(first_hit), "more than one first match")
  `FQC_ASSERT_NXT(a_full_hold, accept && is_enq && full, cnt_r == CNT_W'(DEPTH), "full enqueue changed count")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cancel-by-id queue core. A short table of
// directed commands covers empty, full, duplicate and missing identifiers;
// random traffic then sweeps the queue between empty and full under several
// sender and receiver idle patterns. Every result is checked against an
// in-bench queue predictor or, for some table rows, the row's own result.
// ----------------------------------------------------------------------------
module tb;
  import fqc_pkg::*;

  localparam int DEPTH     = DEPTH_DEF;
  localparam int CYCLE_MAX = 200000;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     fid;
    logic [DATA_W-1:0]   fdata;
    logic [OCC_W-1:0]    occ;
    logic                empty;
  } queue_result_t;

  typedef struct {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    int                reps;
    bit                typed;
    queue_result_t     want;
  } stim_row_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind       = '0;
  logic [ID_W-1:0]     in_entry_id   = '0;
  logic [DATA_W-1:0]   in_entry_data = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_found_id;
  logic [DATA_W-1:0]   out_found_data;
  logic [OCC_W-1:0]    out_occupancy;
  logic                out_is_empty;

  // predictor state: packed queue, front in slot 0
  logic [ID_W-1:0]   held_id   [DEPTH];
  logic [DATA_W-1:0] held_data [DEPTH];
  int                held = 0;

  queue_result_t pending_results[$];
  stim_row_t     stim_rows[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;

  fifo_queue_with_cancel_by_id_core #(.DEPTH(DEPTH)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_entry_id    (in_entry_id),
    .in_entry_data  (in_entry_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found_id   (out_found_id),
    .out_found_data (out_found_data),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_MAX) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Apply one command to the queue copy and return the result it produces.
  function automatic queue_result_t predict_queue_op(kind_t k, logic [ID_W-1:0] key,
                                                     logic [DATA_W-1:0] d);
    queue_result_t r;
    int            pos;
    r.status = ST_DONE;
    r.fid    = '0;
    r.fdata  = '0;
    pos      = -1;
    case (k)
      KIND_ENQ: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_id[held]   = key;
          held_data[held] = d;
          held++;
        end
      end
      KIND_DEQ: begin
        if (held == 0) r.status = ST_MISS;
        else pos = 0;
      end
      default: begin
        for (int i = 0; i < held; i++)
          if (pos < 0 && held_id[i] == key) pos = i;
        if (pos < 0) r.status = ST_MISS;
      end
    endcase
    if (pos >= 0) begin
      r.fid   = held_id[pos];
      r.fdata = held_data[pos];
      if (k != KIND_LOOKUP) begin
        // close the gap behind the removed entry
        for (int i = pos; i < held - 1; i++) begin
          held_id[i]   = held_id[i + 1];
          held_data[i] = held_data[i + 1];
        end
        held--;
      end
    end
    r.occ   = OCC_W'(held);
    r.empty = (held == 0);
    return r;
  endfunction

  // Drive one transaction; entered and left at a falling edge.
  task automatic send_cmd(kind_t k, logic [ID_W-1:0] key, logic [DATA_W-1:0] d,
                          bit typed, queue_result_t want);
    queue_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_entry_id   <= key;
    in_entry_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_queue_op(k, key, d);
    pending_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic add_row(kind_t k, logic [ID_W-1:0] key, logic [DATA_W-1:0] d, int reps,
                         bit typed, status_t st, logic [OCC_W-1:0] occ, logic empty);
    stim_row_t row;
    row.kind         = k;
    row.id           = key;
    row.data         = d;
    row.reps         = reps;
    row.typed        = typed;
    row.want.status  = st;
    row.want.fid     = '0;
    row.want.fdata   = '0;
    row.want.occ     = occ;
    row.want.empty   = empty;
    stim_rows.push_back(row);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, out_status);
          mismatch_count++;
        end
        if (out_found_id !== exp_r.fid) begin
          $error("found_id expected %h got %h", exp_r.fid, out_found_id);
          mismatch_count++;
        end
        if (out_found_data !== exp_r.fdata) begin
          $error("found_data expected %h got %h", exp_r.fdata, out_found_data);
          mismatch_count++;
        end
        if (out_occupancy !== exp_r.occ) begin
          $error("occupancy expected %0d got %0d", exp_r.occ, out_occupancy);
          mismatch_count++;
        end
        if (out_is_empty !== exp_r.empty) begin
          $error("is_empty expected %0d got %0d", exp_r.empty, out_is_empty);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    queue_result_t     none;
    kind_t             k;
    logic [ID_W-1:0]   key;
    int                roll;
    bit                filling;
    none    = '0;
    filling = 1'b1;

    // empty queue, extremes, duplicates, full, removal at back/front/middle
    add_row(KIND_DEQ,    16'h0000, 32'h0000_0000,  1, 1'b1, ST_MISS, 5'd0,  1'b1);
    add_row(KIND_LOOKUP, 16'h0000, 32'hFFFF_FFFF,  1, 1'b1, ST_MISS, 5'd0,  1'b1);
    add_row(KIND_CANCEL, 16'hFFFF, 32'h0000_0000,  1, 1'b1, ST_MISS, 5'd0,  1'b1);
    add_row(KIND_ENQ,    16'h0000, 32'h0000_0000,  1, 1'b1, ST_DONE, 5'd1,  1'b0);
    add_row(KIND_ENQ,    16'hFFFF, 32'hFFFF_FFFF,  1, 1'b1, ST_DONE, 5'd2,  1'b0);
    add_row(KIND_ENQ,    16'h0005, 32'hA5A5_A5A5,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_ENQ,    16'h0005, 32'h5A5A_5A5A,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_LOOKUP, 16'h0005, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_CANCEL, 16'h0005, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_LOOKUP, 16'h0005, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_LOOKUP, 16'hFFFF, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_CANCEL, 16'h1234, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_DEQ,    16'h0000, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_ENQ,    16'h0100, 32'h8000_0000, 14, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_ENQ,    16'h7777, 32'h1234_5678,  1, 1'b1, ST_FULL, 5'd16, 1'b0);
    add_row(KIND_LOOKUP, 16'h010D, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_CANCEL, 16'h010D, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_CANCEL, 16'hFFFF, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_CANCEL, 16'h0107, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_DEQ,    16'h0000, 32'h0000_0000, 13, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_DEQ,    16'h0000, 32'h0000_0000,  1, 1'b1, ST_MISS, 5'd0,  1'b1);
    add_row(KIND_CANCEL, 16'h0005, 32'h0000_0000,  1, 1'b1, ST_MISS, 5'd0,  1'b1);
    add_row(KIND_ENQ,    16'h8000, 32'h0000_0001,  1, 1'b0, ST_DONE, 5'd0,  1'b0);
    add_row(KIND_CANCEL, 16'h8000, 32'h0000_0000,  1, 1'b0, ST_DONE, 5'd0,  1'b0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[n])
      for (int rep = 0; rep < stim_rows[n].reps; rep++)
        send_cmd(stim_rows[n].kind, stim_rows[n].id + ID_W'(rep),
                 stim_rows[n].data + DATA_W'(rep), stim_rows[n].typed, stim_rows[n].want);

    for (int phase = 0; phase < 4; phase++) begin
      // hold the sender until the queue of expected results is empty
      drain_results();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (125) begin
        // sweep the fill level between empty and full
        if (held >= DEPTH) filling = 1'b0;
        else if (held == 0) filling = 1'b1;
        else if ($urandom_range(39) == 0) filling = !filling;
        roll = $urandom_range(99);
        if (filling)
          k = (roll < 55) ? KIND_ENQ : (roll < 65) ? KIND_DEQ :
              (roll < 80) ? KIND_CANCEL : KIND_LOOKUP;
        else
          k = (roll < 15) ? KIND_ENQ : (roll < 50) ? KIND_DEQ :
              (roll < 80) ? KIND_CANCEL : KIND_LOOKUP;
        if ((k == KIND_CANCEL || k == KIND_LOOKUP) && held > 0 && $urandom_range(9) < 7)
          key = held_id[$urandom_range(held - 1)];
        else if ($urandom_range(9) < 6)
          key = ID_W'($urandom_range(15));
        else
          key = ID_W'($urandom_range(65535));
        send_cmd(k, key, $urandom(), 1'b0, none);
      end
    end

    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
